// ===== sv/script_token_scanner_unit_macros.svh =====
// ----------------------------------------------------------------------------
// script_token_scanner_unit_macros
// Assertion macros used by the token scanner RTL.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_SCANNER_UNIT_MACROS_SVH
`define SCRIPT_TOKEN_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Result word type and token and error codes of the token scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sts_pkg;

    localparam logic [2:0] KIND_IDENT  = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_STRING = 3'd2;
    localparam logic [2:0] KIND_EQUALS = 3'd3;
    localparam logic [2:0] KIND_SEP    = 3'd4;
    localparam logic [2:0] KIND_END    = 3'd5;
    localparam logic [2:0] KIND_ERROR  = 3'd6;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_SIGN        = 3'd1;
    localparam logic [2:0] ERR_ESCAPE      = 3'd2;
    localparam logic [2:0] ERR_STR_NEWLINE = 3'd3;
    localparam logic [2:0] ERR_STR_END     = 3'd4;
    localparam logic [2:0] ERR_INVALID     = 3'd5;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  content_byte;
        logic        has_byte;
        logic        token_first;
        logic        token_last;
        logic [31:0] start_line;
        logic [15:0] start_column;
        logic [2:0]  error_code;
        logic        last_of_item;
    } sts_result_t;

endpackage

// ===== sv/sts_scan_core.sv =====
// ----------------------------------------------------------------------------
// sts_scan_core
// Scan mode machine and position counters; one text word per step, up to
// two result words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sts_scan_core
    import sts_pkg::*;
#(
    parameter int LINE_BITS   = 32,
    parameter int COLUMN_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output sts_result_t res0,
    output sts_result_t res1,
    output logic [1:0]  res_count
);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_PLUS,
        MODE_MINUS,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_COMMENT,
        MODE_HALT
    } mode_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_LOW_R = 8'h72;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

    mode_t                  mode_reg, mode_next;
    logic                   acr_reg, acr_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [LINE_BITS-1:0]   tline_reg, tline_next;
    logic [COLUMN_BITS-1:0] tcol_reg, tcol_next;

    sts_result_t res_c [2];
    logic [1:0]  n_c;
    logic        rescan;
    logic [7:0]  esc_val;
    logic        esc_ok;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic sts_result_t mk(
        input logic [2:0]             kind,
        input logic [7:0]             data,
        input logic                   has,
        input logic                   first,
        input logic                   last,
        input logic [LINE_BITS-1:0]   line,
        input logic [COLUMN_BITS-1:0] col,
        input logic [2:0]             err
    );
        sts_result_t r;
        r.token_kind   = kind;
        r.content_byte = data;
        r.has_byte     = has;
        r.token_first  = first;
        r.token_last   = last;
        r.start_line   = 32'(line);
        r.start_column = 16'(col);
        r.error_code   = err;
        r.last_of_item = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        acr_next   = acr_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        res_c[0]   = '0;
        res_c[1]   = '0;
        n_c        = 2'd0;
        rescan     = 1'b0;
        esc_ok     = 1'b1;
        esc_val    = text_byte;

        if (step && mode_reg != MODE_HALT)
        begin
            if (end_of_text)
            begin
                unique case (mode_reg) inside
                    MODE_IDENT, MODE_NUMBER:
                    begin
                        res_c[n_c[0]] = mk((mode_reg == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER,
                            8'h00, 1'b0, 1'b0, 1'b1, tline_next, tcol_next, ERR_NONE);
                        n_c = n_c + 2'd1;
                        tline_next = line_reg;
                        tcol_next  = col_reg;
                        res_c[n_c[0]] = mk(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1,
                            tline_next, tcol_next, ERR_NONE);
                        n_c = n_c + 2'd1;
                    end
                    MODE_PLUS, MODE_MINUS, MODE_STRING, MODE_ESCAPE:
                    begin
                        tline_next = line_reg;
                        tcol_next  = col_reg;
                        res_c[n_c[0]] = mk(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1,
                            tline_next, tcol_next,
                            (mode_reg == MODE_STRING) ? ERR_STR_END :
                            (mode_reg == MODE_ESCAPE) ? ERR_ESCAPE : ERR_SIGN);
                        n_c = n_c + 2'd1;
                    end
                    default:
                    begin
                        // idle or inside a comment: plain end token
                        tline_next = line_reg;
                        tcol_next  = col_reg;
                        res_c[n_c[0]] = mk(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1,
                            tline_next, tcol_next, ERR_NONE);
                        n_c = n_c + 2'd1;
                    end
                endcase
                mode_next = MODE_HALT;
            end
            else if (acr_reg && text_byte == CH_LF)
            begin
                // drop the LF of a CR LF pair
                acr_next = 1'b0;
            end
            else
            begin
                unique case (mode_reg) inside
                    MODE_IDLE:
                        rescan = 1'b1;
                    MODE_IDENT, MODE_NUMBER:
                    begin
                        if (is_digit(text_byte) || (mode_reg == MODE_IDENT && is_alpha(text_byte)))
                        begin
                            res_c[n_c[0]] = mk((mode_reg == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER,
                                text_byte, 1'b1, 1'b0, 1'b0, tline_next, tcol_next, ERR_NONE);
                            n_c = n_c + 2'd1;
                        end
                        else
                        begin
                            res_c[n_c[0]] = mk((mode_reg == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER,
                                8'h00, 1'b0, 1'b0, 1'b1, tline_next, tcol_next, ERR_NONE);
                            n_c = n_c + 2'd1;
                            mode_next = MODE_IDLE;
                            rescan = 1'b1;
                        end
                    end
                    MODE_PLUS, MODE_MINUS:
                    begin
                        if (is_digit(text_byte))
                        begin
                            res_c[n_c[0]] = mk(KIND_NUMBER,
                                (mode_reg == MODE_PLUS) ? CH_PLUS : CH_MINUS,
                                1'b1, 1'b1, 1'b0, tline_next, tcol_next, ERR_NONE);
                            n_c = n_c + 2'd1;
                            res_c[n_c[0]] = mk(KIND_NUMBER, text_byte, 1'b1, 1'b0, 1'b0,
                                tline_next, tcol_next, ERR_NONE);
                            n_c = n_c + 2'd1;
                            mode_next = MODE_NUMBER;
                        end
                        else
                        begin
                            tline_next = line_reg;
                            tcol_next  = col_reg;
                            res_c[n_c[0]] = mk(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1,
                                tline_next, tcol_next, ERR_SIGN);
                            n_c = n_c + 2'd1;
                            mode_next = MODE_HALT;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (text_byte == CH_QUOTE)
                        begin
                            res_c[n_c[0]] = mk(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1,
                                tline_next, tcol_next, ERR_NONE);
                            n_c = n_c + 2'd1;
                            mode_next = MODE_IDLE;
                        end
                        else if (text_byte == CH_BSL)
                        begin
                            mode_next = MODE_ESCAPE;
                        end
                        else if (text_byte == CH_LF || text_byte == CH_CR)
                        begin
                            tline_next = line_reg;
                            tcol_next  = col_reg;
                            res_c[n_c[0]] = mk(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1,
                                tline_next, tcol_next, ERR_STR_NEWLINE);
                            n_c = n_c + 2'd1;
                            mode_next = MODE_HALT;
                        end
                        else
                        begin
                            res_c[n_c[0]] = mk(KIND_STRING, text_byte, 1'b1, 1'b0, 1'b0,
                                tline_next, tcol_next, ERR_NONE);
                            n_c = n_c + 2'd1;
                        end
                    end
                    MODE_ESCAPE:
                    begin
                        if (text_byte == CH_BSL || text_byte == CH_QUOTE || text_byte == CH_APOS)
                            esc_val = text_byte;
                        else if (text_byte == CH_LOW_N)
                            esc_val = CH_LF;
                        else if (text_byte == CH_LOW_R)
                            esc_val = CH_CR;
                        else
                            esc_ok = 1'b0;
                        if (esc_ok)
                        begin
                            res_c[n_c[0]] = mk(KIND_STRING, esc_val, 1'b1, 1'b0, 1'b0,
                                tline_next, tcol_next, ERR_NONE);
                            n_c = n_c + 2'd1;
                            mode_next = MODE_STRING;
                        end
                        else
                        begin
                            tline_next = line_reg;
                            tcol_next  = col_reg;
                            res_c[n_c[0]] = mk(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1,
                                tline_next, tcol_next, ERR_ESCAPE);
                            n_c = n_c + 2'd1;
                            mode_next = MODE_HALT;
                        end
                    end
                    MODE_COMMENT:
                    begin
                        if (text_byte == CH_LF || text_byte == CH_CR)
                        begin
                            mode_next = MODE_IDLE;
                            rescan = 1'b1;
                        end
                    end
                    default:
                        mode_next = MODE_HALT;
                endcase

                // scan the byte as the start of a new token
                if (rescan)
                begin
                    tline_next = line_reg;
                    tcol_next  = col_reg;
                    if (text_byte == CH_NUL || text_byte == CH_SPACE || text_byte == CH_TAB
                        || text_byte == CH_VT || text_byte == CH_FF)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (text_byte == CH_HASH)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else if (is_alpha(text_byte) || is_digit(text_byte))
                    begin
                        res_c[n_c[0]] = mk(is_alpha(text_byte) ? KIND_IDENT : KIND_NUMBER,
                            text_byte, 1'b1, 1'b1, 1'b0, tline_next, tcol_next, ERR_NONE);
                        n_c = n_c + 2'd1;
                        mode_next = is_alpha(text_byte) ? MODE_IDENT : MODE_NUMBER;
                    end
                    else if (text_byte == CH_PLUS)
                    begin
                        mode_next = MODE_PLUS;
                    end
                    else if (text_byte == CH_MINUS)
                    begin
                        mode_next = MODE_MINUS;
                    end
                    else if (text_byte == CH_QUOTE)
                    begin
                        res_c[n_c[0]] = mk(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0,
                            tline_next, tcol_next, ERR_NONE);
                        n_c = n_c + 2'd1;
                        mode_next = MODE_STRING;
                    end
                    else if (text_byte == CH_EQ || text_byte == CH_SEMI
                        || text_byte == CH_LF || text_byte == CH_CR)
                    begin
                        res_c[n_c[0]] = mk((text_byte == CH_EQ) ? KIND_EQUALS : KIND_SEP,
                            8'h00, 1'b0, 1'b1, 1'b1, tline_next, tcol_next, ERR_NONE);
                        n_c = n_c + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        res_c[n_c[0]] = mk(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1,
                            tline_next, tcol_next, ERR_INVALID);
                        n_c = n_c + 2'd1;
                        mode_next = MODE_HALT;
                    end
                end

                acr_next = (text_byte == CH_CR);
                if (mode_next != MODE_HALT)
                begin
                    if (text_byte == CH_LF || text_byte == CH_CR)
                    begin
                        if (line_reg < LINE_MAX)
                            line_next = line_reg + LINE_ONE;
                        col_next = COL_ONE;
                    end
                    else if (col_reg < COL_MAX)
                    begin
                        col_next = col_reg + COL_ONE;
                    end
                end
            end
        end

        if (n_c == 2'd1)
            res_c[0].last_of_item = 1'b1;
        else if (n_c == 2'd2)
            res_c[1].last_of_item = 1'b1;
    end

    assign res0      = res_c[0];
    assign res1      = res_c[1];
    assign res_count = n_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            acr_reg   <= 1'b0;
            line_reg  <= LINE_ONE;
            col_reg   <= COL_ONE;
            tline_reg <= LINE_ONE;
            tcol_reg  <= COL_ONE;
        end
        else
        begin
            mode_reg  <= mode_next;
            acr_reg   <= acr_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
        end
    end

endmodule

// ===== sv/sts_result_fifo.sv =====
// ----------------------------------------------------------------------------
// sts_result_fifo
// Four-word result queue; takes up to two words a cycle, gives one while rd_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sts_result_fifo
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  wr_count,
    input  sts_result_t wr_data0,
    input  sts_result_t wr_data1,
    input  logic        rd_ready,
    output logic        rd_valid,
    output sts_result_t rd_data,
    output logic        room_for_two
);

    sts_result_t mem [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic        rd_fire;

    assign rd_valid     = (count_reg != 3'd0);
    assign rd_data      = mem[rd_ptr_reg];
    assign rd_fire      = rd_valid && rd_ready;
    assign room_for_two = (count_reg <= 3'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + wr_count;
        rd_ptr_next = rd_ptr_reg + {1'b0, rd_fire};
        count_next  = count_reg + {1'b0, wr_count} - {2'b00, rd_fire};
    end

    always_ff @(posedge clk)
    begin
        if (wr_count != 2'd0)
            mem[wr_ptr_reg] <= wr_data0;
        if (wr_count == 2'd2)
            mem[wr_ptr_reg + 2'd1] <= wr_data1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/script_token_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// script_token_scanner_unit
// Streaming tokenizer: one text byte per word in, token words out.
// ----------------------------------------------------------------------------
// Path: input register, then scan step, then the registered result queue.
// Throughput: one text word per cycle while each word causes at most one
//   result and the output does not stall; two results of one word leave
//   in turn on the single output port, which drains a four-word result queue.
// Reset: rst_n clears the input register, queue and scan mode at once; the
//   line and column counters start at 1.
`timescale 1ns / 1ps

`include "script_token_scanner_unit_macros.svh"

module script_token_scanner_unit
    import sts_pkg::*;
#(
    parameter int LINE_BITS   = 32,
    parameter int COLUMN_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // text input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_tuser,   // [0] end_of_text
    // token output
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] content_byte, [8] has_byte, [9] token_first, [41:10] start_line,
    // [57:42] start_column, [60:58] error_code, [61] last_of_item, [63:62] zero
    output logic [63:0] m_tdata,
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast    // token_last
);

    // input register: holds one text word until the queue has room for two
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_eot_reg;
    logic        s_fire;
    logic        step;
    logic        room_for_two;

    sts_result_t res0, res1, out_word;
    logic [1:0]  res_count;

    assign step     = in_valid_reg && room_for_two;
    assign s_tready = !in_valid_reg || room_for_two;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tuser[0];
        end
    end

    // scan one word: mode update and up to two result words
    sts_scan_core #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .res0        (res0),
        .res1        (res1),
        .res_count   (res_count)
    );

    // result queue: parts the scanner from output stalls
    sts_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_count     (res_count),
        .wr_data0     (res0),
        .wr_data1     (res1),
        .rd_ready     (m_tready),
        .rd_valid     (m_tvalid),
        .rd_data      (out_word),
        .room_for_two (room_for_two)
    );

    assign m_tuser = out_word.token_kind;
    assign m_tlast = out_word.token_last;
    assign m_tdata = {2'b00,
                      out_word.last_of_item,
                      out_word.error_code,
                      out_word.start_column,
                      out_word.start_line,
                      out_word.token_first,
                      out_word.has_byte,
                      out_word.content_byte};

    // results appear only on a scan step
    `STS_ASSERT_NOW(a_no_result_without_step, clk, rst_n, !step, res_count == 2'd0, "result without step")
    // the second of two results closes the item, the first does not
    `STS_ASSERT_NOW(a_pair_order, clk, rst_n, res_count == 2'd2, res1.last_of_item && !res0.last_of_item, "bad item end mark")
    // error code set exactly on error words
    `STS_ASSERT_NOW(a_error_code, clk, rst_n, m_tvalid, (m_tuser == KIND_ERROR) == (out_word.error_code != ERR_NONE), "error code mismatch")
    // an accepted word is held in the input register
    `STS_ASSERT_NEXT(a_in_held, clk, rst_n, s_fire, in_valid_reg, "accepted word lost")

endmodule

// ===== test/sts_token_checker.sv =====
// ----------------------------------------------------------------------------
// sts_token_checker
// Watches both stream channels of the token scanner, predicts the token
// words from the accepted text words and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sts_token_checker
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_tuser,   // [0] end_of_text
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] content_byte, [8] has_byte, [9] token_first, [41:10] start_line,
    // [57:42] start_column, [60:58] error_code, [61] last_of_item
    input  logic [63:0] m_tdata,
    input  logic [2:0]  m_tuser,   // [2:0] token_kind
    input  logic        m_tlast,   // token_last
    output int          fail_count,
    output int          pending_count,
    output int          words_checked
);

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;

    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_PLUS,
        SCAN_MINUS,
        SCAN_STRING,
        SCAN_ESCAPE,
        SCAN_COMMENT,
        SCAN_HALT
    } scan_mode_t;

    // Scanner state mirrored from the text stream
    scan_mode_t  scan_mode = SCAN_IDLE;
    logic        after_cr  = 1'b0;
    logic [31:0] line_no   = 32'd1;
    logic [15:0] col_no    = 16'd1;
    logic [31:0] tok_line  = 32'd1;
    logic [15:0] tok_col   = 16'd1;

    sts_result_t item_words [$];
    sts_result_t expected_tokens [$];
    sts_result_t want;
    sts_result_t got;
    int          errors  = 0;
    int          checked = 0;

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    // At most two words leave per text word; drop anything beyond that.
    task automatic add_word(input logic [2:0] kind, input logic [7:0] b,
                            input logic has, input logic first, input logic last,
                            input logic [2:0] code);
        sts_result_t w;
        w.token_kind   = kind;
        w.content_byte = b;
        w.has_byte     = has;
        w.token_first  = first;
        w.token_last   = last;
        w.start_line   = tok_line;
        w.start_column = tok_col;
        w.error_code   = code;
        w.last_of_item = 1'b0;
        if (item_words.size() < 2)
        begin
            item_words.push_back(w);
        end
    endtask

    task automatic add_single(input logic [2:0] kind);
        tok_line = line_no;
        tok_col  = col_no;
        add_word(kind, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
    endtask

    task automatic add_error(input logic [2:0] code);
        tok_line = line_no;
        tok_col  = col_no;
        add_word(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1, code);
        scan_mode = SCAN_HALT;
    endtask

    task automatic scan_between(input logic [7:0] b);
        tok_line = line_no;
        tok_col  = col_no;
        if (b == 8'h00 || b == " " || b == 8'h09 || b == 8'h0B || b == 8'h0C)
        begin
            return;
        end
        if (b == "#")
        begin
            scan_mode = SCAN_COMMENT;
        end
        else if (is_letter(b))
        begin
            add_word(KIND_IDENT, b, 1'b1, 1'b1, 1'b0, ERR_NONE);
            scan_mode = SCAN_IDENT;
        end
        else if (is_digit(b))
        begin
            add_word(KIND_NUMBER, b, 1'b1, 1'b1, 1'b0, ERR_NONE);
            scan_mode = SCAN_NUMBER;
        end
        else if (b == "+")
        begin
            scan_mode = SCAN_PLUS;
        end
        else if (b == "-")
        begin
            scan_mode = SCAN_MINUS;
        end
        else if (b == CH_DQ)
        begin
            add_word(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
            scan_mode = SCAN_STRING;
        end
        else if (b == "=")
        begin
            add_single(KIND_EQUALS);
        end
        else if (b == ";" || b == CH_LF || b == CH_CR)
        begin
            add_single(KIND_SEP);
        end
        else
        begin
            add_error(ERR_INVALID);
        end
    endtask

    task automatic scan_text(input logic [7:0] b);
        logic [2:0] kind;
        logic [7:0] v;
        case (scan_mode) inside
            SCAN_IDLE:
                scan_between(b);
            SCAN_IDENT, SCAN_NUMBER:
            begin
                kind = (scan_mode == SCAN_IDENT) ? KIND_IDENT : KIND_NUMBER;
                if (is_digit(b) || (scan_mode == SCAN_IDENT && is_letter(b)))
                begin
                    add_word(kind, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
                end
                else
                begin
                    // close the token, then rescan the byte between tokens
                    add_word(kind, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                    scan_mode = SCAN_IDLE;
                    scan_between(b);
                end
            end
            SCAN_PLUS, SCAN_MINUS:
            begin
                if (is_digit(b))
                begin
                    v = (scan_mode == SCAN_PLUS) ? "+" : "-";
                    add_word(KIND_NUMBER, v, 1'b1, 1'b1, 1'b0, ERR_NONE);
                    add_word(KIND_NUMBER, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    scan_mode = SCAN_NUMBER;
                end
                else
                begin
                    add_error(ERR_SIGN);
                end
            end
            SCAN_STRING:
            begin
                if (b == CH_DQ)
                begin
                    add_word(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                    scan_mode = SCAN_IDLE;
                end
                else if (b == CH_BSL)
                begin
                    scan_mode = SCAN_ESCAPE;
                end
                else if (b == CH_LF || b == CH_CR)
                begin
                    add_error(ERR_STR_NEWLINE);
                end
                else
                begin
                    add_word(KIND_STRING, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
                end
            end
            SCAN_ESCAPE:
            begin
                if (b == CH_BSL || b == CH_DQ || b == CH_SQ || b == "n" || b == "r")
                begin
                    v = (b == "n") ? CH_LF : (b == "r") ? CH_CR : b;
                    add_word(KIND_STRING, v, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    scan_mode = SCAN_STRING;
                end
                else
                begin
                    add_error(ERR_ESCAPE);
                end
            end
            SCAN_COMMENT:
            begin
                if (b == CH_LF || b == CH_CR)
                begin
                    scan_mode = SCAN_IDLE;
                    scan_between(b);
                end
            end
            default:
                scan_mode = SCAN_HALT;
        endcase
    endtask

    task automatic scan_end();
        case (scan_mode) inside
            SCAN_IDLE, SCAN_COMMENT:
                add_single(KIND_END);
            SCAN_IDENT, SCAN_NUMBER:
            begin
                add_word((scan_mode == SCAN_IDENT) ? KIND_IDENT : KIND_NUMBER,
                         8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                add_single(KIND_END);
            end
            SCAN_PLUS, SCAN_MINUS:
                add_error(ERR_SIGN);
            SCAN_STRING:
                add_error(ERR_STR_END);
            SCAN_ESCAPE:
                add_error(ERR_ESCAPE);
            default:
                ;
        endcase
        scan_mode = SCAN_HALT;
    endtask

    task automatic predict_word(input logic [7:0] b, input logic eot);
        sts_result_t w;
        item_words.delete();
        if (scan_mode == SCAN_HALT)
        begin
            return;
        end
        if (eot)
        begin
            scan_end();
        end
        else if (after_cr && b == CH_LF)
        begin
            after_cr = 1'b0;
        end
        else
        begin
            scan_text(b);
            after_cr = (b == CH_CR);
            if (scan_mode != SCAN_HALT)
            begin
                if (b == CH_LF || b == CH_CR)
                begin
                    if (line_no != 32'hFFFF_FFFF)
                    begin
                        line_no = line_no + 32'd1;
                    end
                    col_no = 16'd1;
                end
                else if (col_no != 16'hFFFF)
                begin
                    col_no = col_no + 16'd1;
                end
            end
        end
        if (item_words.size() > 0)
        begin
            w = item_words.pop_back();
            w.last_of_item = 1'b1;
            item_words.push_back(w);
            foreach (item_words[i])
            begin
                expected_tokens.push_back(item_words[i]);
            end
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0h, got %0h", field, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            scan_mode = SCAN_IDLE;
            after_cr  = 1'b0;
            line_no   = 32'd1;
            col_no    = 16'd1;
            tok_line  = 32'd1;
            tok_col   = 16'd1;
        end
        else
        begin
            // Compare first: a result never leaves in the cycle its text arrives.
            if (m_tvalid && m_tready)
            begin
                got.token_kind   = m_tuser;
                got.content_byte = m_tdata[7:0];
                got.has_byte     = m_tdata[8];
                got.token_first  = m_tdata[9];
                got.token_last   = m_tlast;
                got.start_line   = m_tdata[41:10];
                got.start_column = m_tdata[57:42];
                got.error_code   = m_tdata[60:58];
                got.last_of_item = m_tdata[61];
                if (expected_tokens.size() == 0)
                begin
                    $error("token word with none expected: kind %0d data %h",
                           got.token_kind, m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.token_kind, got.token_kind);
                    check_field("content_byte", want.content_byte, got.content_byte);
                    check_field("has_byte", want.has_byte, got.has_byte);
                    check_field("token_first", want.token_first, got.token_first);
                    check_field("token_last", want.token_last, got.token_last);
                    check_field("start_line", want.start_line, got.start_line);
                    check_field("start_column", want.start_column, got.start_column);
                    check_field("error_code", want.error_code, got.error_code);
                    check_field("last_of_item", want.last_of_item, got.last_of_item);
                end
                checked++;
            end
            if (s_tvalid && s_tready)
            begin
                predict_word(s_tdata, s_tuser[0]);
            end
        end
        fail_count    <= errors;
        pending_count <= expected_tokens.size();
        words_checked <= checked;
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the token scanner: directed text, one line of
// tokens without breaks, random well-formed script text under several
// idling mixes, and one randomly chosen way of ending the text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_BSL = 8'h5C;

    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_LIMIT     = 5000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] text_byte
    logic [0:0]  s_tuser  = 1'b0;    // [0] end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] content_byte, [8] has_byte, [9] token_first, [41:10] start_line,
    // [57:42] start_column, [60:58] error_code, [61] last_of_item
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;            // [2:0] token_kind
    logic        m_tlast;            // token_last

    int fail_count;
    int pending_count;
    int words_checked;

    // Idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Long receiver hold-off, counted down in the receiver process
    logic long_hold  = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;

    int          counted_words = 0;
    int          all_words     = 0;
    int          guard;
    int          term_case;
    logic [7:0]  stray;
    logic [7:0]  directed_text [0:32];
    string       term_names [0:10];

    script_token_scanner_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sts_token_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .words_checked (words_checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random stalls, or one long hold-off when requested
    always @(posedge clk)
    begin
        if (long_hold && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("timeout: the run did not finish in time");
        $display("FAIL script_token_scanner_unit");
        $finish;
    end

    // Offer one text word, idling at random first; return once accepted.
    // Ignored words (spaces, comment bodies) do not count toward a phase's target.
    task automatic send_word(input logic [7:0] b, input logic eot, input bit counts);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eot;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        all_words++;
        if (counts)
        begin
            counted_words++;
        end
    endtask

    function automatic logic [7:0] letter_byte();
        int pick;
        pick = $urandom_range(52);
        if (pick < 26)
        begin
            return 8'("A" + pick);
        end
        else if (pick < 52)
        begin
            return 8'("a" + pick - 26);
        end
        return "_";
    endfunction

    function automatic logic [7:0] digit_byte();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] skip_byte();
        case ($urandom_range(4))
            0:       return 8'h00;
            1:       return CH_TAB;
            2:       return CH_VT;
            3:       return CH_FF;
            default: return " ";
        endcase
    endfunction

    // Any byte but a line break; inside strings also no quote or backslash
    function automatic logic [7:0] free_byte(input bit in_string);
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(255));
        end
        while (b == CH_LF || b == CH_CR || (in_string && (b == CH_DQ || b == CH_BSL)));
        return b;
    endfunction

    task automatic send_line_break();
        case ($urandom_range(2))
            0:
                send_word(CH_LF, 1'b0, 1'b1);
            1:
                send_word(CH_CR, 1'b0, 1'b1);
            default:
            begin
                // CR LF counts as one break; the LF gives nothing
                send_word(CH_CR, 1'b0, 1'b1);
                send_word(CH_LF, 1'b0, 1'b1);
            end
        endcase
    endtask

    // One well-formed piece of script text with random content. Without
    // breaks, the piece stays on the current line.
    task automatic send_random_piece(input bit with_breaks);
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            send_word(letter_byte(), 1'b0, 1'b1);
            n = $urandom_range(7);
            repeat (n)
            begin
                send_word(($urandom_range(2) == 0) ? digit_byte() : letter_byte(),
                          1'b0, 1'b1);
            end
        end
        else if (pick < 40)
        begin
            // optional sign, always followed by a digit
            case ($urandom_range(3))
                0:       send_word("+", 1'b0, 1'b1);
                1:       send_word("-", 1'b0, 1'b1);
                default: ;
            endcase
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                send_word(digit_byte(), 1'b0, 1'b1);
            end
        end
        else if (pick < 58)
        begin
            send_word(CH_DQ, 1'b0, 1'b1);
            n = $urandom_range(8);
            repeat (n)
            begin
                if ($urandom_range(3) == 0)
                begin
                    send_word(CH_BSL, 1'b0, 1'b1);
                    case ($urandom_range(4))
                        0:       send_word(CH_BSL, 1'b0, 1'b1);
                        1:       send_word(CH_DQ, 1'b0, 1'b1);
                        2:       send_word(CH_SQ, 1'b0, 1'b1);
                        3:       send_word("n", 1'b0, 1'b1);
                        default: send_word("r", 1'b0, 1'b1);
                    endcase
                end
                else
                begin
                    send_word(free_byte(1'b1), 1'b0, 1'b1);
                end
            end
            send_word(CH_DQ, 1'b0, 1'b1);
        end
        else if (pick < 66)
        begin
            send_word("=", 1'b0, 1'b1);
        end
        else if (pick < 78)
        begin
            if (with_breaks && $urandom_range(1) == 0)
            begin
                send_line_break();
            end
            else
            begin
                send_word(";", 1'b0, 1'b1);
            end
        end
        else if (pick < 90 || !with_breaks)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                send_word(skip_byte(), 1'b0, 1'b0);
            end
        end
        else
        begin
            // comment with arbitrary bytes up to a line break
            send_word("#", 1'b0, 1'b0);
            n = $urandom_range(6);
            repeat (n)
            begin
                send_word(free_byte(1'b0), 1'b0, 1'b0);
            end
            send_line_break();
        end
    endtask

    task automatic run_phase(input int target, input int idle_pct, input int stall_pct);
        int stop_at;
        stop_at = counted_words + target;
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        while (counted_words < stop_at)
        begin
            send_random_piece(1'b1);
        end
    endtask

    initial
    begin
        // Identifier, equals, signed numbers, CR LF, every escape, NUL and
        // 0xFF inside a string, tab, VT, FF and a comment closed by LF.
        directed_text = '{"_", "A", "z", "9", " ", "=", "-", "0", ";", "+", "9",
                          CH_CR, CH_LF, CH_DQ, CH_BSL, CH_BSL, CH_BSL, CH_DQ,
                          CH_BSL, CH_SQ, CH_BSL, "n", CH_BSL, "r", 8'h00, 8'hFF,
                          CH_DQ, CH_TAB, CH_VT, CH_FF, "#", "x", CH_LF};
        term_names = '{"end between tokens", "end inside a comment",
                       "end inside an identifier", "end inside a number",
                       "end after a sign", "sign without digit",
                       "bad escape", "end after a backslash",
                       "line break inside a string", "end inside a string",
                       "invalid character"};

        // Hold reset once, then release it
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed text, no idling
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        foreach (directed_text[i])
        begin
            send_word(directed_text[i], 1'b0, 1'b1);
        end

        // One line of tokens with no breaks in it
        repeat (12)
        begin
            send_random_piece(1'b0);
        end
        send_word(CH_LF, 1'b0, 1'b1);

        // No idling, then half sender idling, with a long receiver hold-off at the
        // start so the result queue fills and the text input stalls
        long_hold <= 1'b1;
        run_phase(200, 0, 0);
        run_phase(200, 50, 0);

        // Pause the sender until every expected token word is out
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end

        run_phase(200, 0, 50);
        run_phase(200, 21, 21);
        run_phase(100, 0, 0);

        // End the text one way; the block halts afterward
        term_case = $urandom_range(10);
        case (term_case)
            0:
            begin
                send_word(";", 1'b0, 1'b1);
                send_word(8'($urandom_range(255)), 1'b1, 1'b1);
            end
            1:
            begin
                send_word("#", 1'b0, 1'b1);
                send_word(free_byte(1'b0), 1'b0, 1'b1);
                send_word(8'($urandom_range(255)), 1'b1, 1'b1);
            end
            2:
            begin
                send_word(";", 1'b0, 1'b1);
                send_word(letter_byte(), 1'b0, 1'b1);
                send_word(8'($urandom_range(255)), 1'b1, 1'b1);
            end
            3:
            begin
                send_word(";", 1'b0, 1'b1);
                send_word(digit_byte(), 1'b0, 1'b1);
                send_word(8'($urandom_range(255)), 1'b1, 1'b1);
            end
            4:
            begin
                send_word("-", 1'b0, 1'b1);
                send_word(8'($urandom_range(255)), 1'b1, 1'b1);
            end
            5:
            begin
                send_word("+", 1'b0, 1'b1);
                send_word(letter_byte(), 1'b0, 1'b1);
            end
            6:
            begin
                send_word(CH_DQ, 1'b0, 1'b1);
                send_word(CH_BSL, 1'b0, 1'b1);
                send_word("q", 1'b0, 1'b1);
            end
            7:
            begin
                send_word(CH_DQ, 1'b0, 1'b1);
                send_word(CH_BSL, 1'b0, 1'b1);
                send_word(8'($urandom_range(255)), 1'b1, 1'b1);
            end
            8:
            begin
                send_word(CH_DQ, 1'b0, 1'b1);
                send_word(free_byte(1'b1), 1'b0, 1'b1);
                send_word(($urandom_range(1) == 0) ? CH_LF : CH_CR, 1'b0, 1'b1);
            end
            9:
            begin
                send_word(CH_DQ, 1'b0, 1'b1);
                send_word(free_byte(1'b1), 1'b0, 1'b1);
                send_word(8'($urandom_range(255)), 1'b1, 1'b1);
            end
            default:
            begin
                send_word(";", 1'b0, 1'b1);
                do
                begin
                    stray = 8'($urandom_range(255));
                end
                while (stray inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                                     8'h5F, 8'h00, 8'h20, CH_TAB, CH_VT, CH_FF,
                                     8'h23, 8'h2B, 8'h2D, CH_DQ, 8'h3D, 8'h3B,
                                     CH_LF, CH_CR});
                send_word(stray, 1'b0, 1'b1);
            end
        endcase

        // Noise after the halt: must give nothing
        repeat (24)
        begin
            send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
        end
        s_tvalid <= 1'b0;

        // Drain, bounded
        @(posedge clk);
        guard = 0;
        while (pending_count != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end

        if (pending_count != 0)
        begin
            $error("%0d expected token words never arrived", pending_count);
            $display("FAIL script_token_scanner_unit");
        end
        else
        begin
            // Let any stray output show up before the verdict
            repeat (16) @(posedge clk);
            $display("Sent %0d text words under four idling mixes, checked %0d token words.",
                     all_words, words_checked);
            $display("Text ended by: %s, then noise after the halt.", term_names[term_case]);
            if (fail_count == 0)
            begin
                $display("PASS script_token_scanner_unit");
            end
            else
            begin
                $display("FAIL script_token_scanner_unit");
            end
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sts_pkg.sv
sv/sts_scan_core.sv
sv/sts_result_fifo.sv
sv/script_token_scanner_unit.sv
test/sts_token_checker.sv
test/tb_top.sv
